### src/ets_pkg.sv
// ets_pkg: constants, types and the month table for the epoch-to-local-date pipeline.
// No dependencies; imported by every module of the block but ets_checker.
package ets_pkg;

    // Local zone is eight hours ahead of UTC.
    localparam logic [32:0] ZONE_OFFSET_SEC = 33'd28800;

    // floor(2^35 / 15): x / 60 == ((x >> 2) * DIV15_MUL) >> 35, low by at most one.
    localparam logic [31:0] DIV15_MUL = 32'((64'd1 << 35) / 64'd15);

    // Four-year span (one leap year) in hours, and its reciprocal with a 36-bit shift.
    localparam logic [15:0] SPAN_HOURS = 16'd35064;
    localparam logic [20:0] SPAN_MUL   = 21'((64'd1 << 36) / 64'd35064);

    localparam logic [13:0] YEAR_HOURS      = 14'd8760;
    localparam logic [13:0] LEAP_YEAR_HOURS = 14'd8784;

    // floor(2^16 / 24) for the hours-to-days split.
    localparam logic [11:0] DAY_MUL       = 12'((32'd1 << 16) / 32'd24);
    localparam logic [4:0]  HOURS_PER_DAY = 5'd24;

    localparam logic [11:0] EPOCH_YEAR = 12'd1970;

    // Zero-based day of year of Feb 29 in a leap year.
    localparam logic [8:0] LEAP_DAY_DOY = 9'd59;

    // Minute and second carried alongside the pipeline.
    typedef struct packed {
        logic [5:0] minute;
        logic [5:0] second;
    } ets_ms_t;

    // First zero-based day of each month in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] s;
        case (idx)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

### src/ets_div60.sv
// ets_div60: two-stage divide by 60 (reciprocal multiply, then correction).
// The remainder is shifted into the minute/second side word. Uses ets_pkg.
module ets_div60 (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [32:0]     in_value,
    input  ets_pkg::ets_ms_t in_ms,
    output logic            out_valid,
    output logic [26:0]     out_quot,
    output ets_pkg::ets_ms_t out_ms
);
    import ets_pkg::*;

    logic        v1_reg;
    logic [32:0] val1_reg;
    logic [62:0] prod_reg;
    ets_ms_t     ms1_reg;

    logic        v2_reg;
    logic [26:0] quot_reg;
    ets_ms_t     ms2_reg;

    logic [62:0] prod_next;
    logic [27:0] q_est;
    logic [32:0] q_x60;
    logic [6:0]  rem_raw;
    logic [26:0] quot_next;
    ets_ms_t     ms_next;

    assign prod_next = in_value[32:2] * DIV15_MUL;

    // New remainder enters the minute slot; the previous one moves down to second.
    always_comb
    begin
        q_est   = prod_reg[62:35];
        q_x60   = 33'({q_est, 6'b0}) - 33'({q_est, 2'b0});
        rem_raw = 7'(val1_reg - q_x60);
        ms_next.second = ms1_reg.minute;
        if (rem_raw >= 7'd60)
        begin
            quot_next      = 27'(q_est + 28'd1);
            ms_next.minute = 6'(rem_raw - 7'd60);
        end
        else
        begin
            quot_next      = 27'(q_est);
            ms_next.minute = 6'(rem_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val1_reg <= in_value;
            prod_reg <= prod_next;
            ms1_reg  <= in_ms;
            quot_reg <= quot_next;
            ms2_reg  <= ms_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_quot  = quot_reg;
    assign out_ms    = ms2_reg;

endmodule

### src/ets_year.sv
// ets_year: three stages from hours since epoch to year, leap flag and hour of year.
// Splits off four-year spans by reciprocal multiply, then walks the years. Uses ets_pkg.
module ets_year (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [20:0]     in_hours,
    input  ets_pkg::ets_ms_t in_ms,
    output logic            out_valid,
    output logic [11:0]     out_year,
    output logic            out_leap,
    output logic [13:0]     out_rem,
    output ets_pkg::ets_ms_t out_ms
);
    import ets_pkg::*;

    // stage a: multiply
    logic        va_reg;
    logic [20:0] hours_a_reg;
    logic [41:0] prod_a_reg;
    ets_ms_t     ms_a_reg;
    // stage b: span count and hour within span
    logic        vb_reg;
    logic [5:0]  span_b_reg;
    logic [15:0] rem_b_reg;
    ets_ms_t     ms_b_reg;
    // stage c: year walk
    logic        vc_reg;
    logic [11:0] year_c_reg;
    logic        leap_c_reg;
    logic [13:0] rem_c_reg;
    ets_ms_t     ms_c_reg;

    logic [41:0] prod_next;
    logic [5:0]  span_est;
    logic [20:0] span_x;
    logic [16:0] rem_raw;
    logic [5:0]  span_next;
    logic [15:0] rem_b_next;
    logic [1:0]  yoff;
    logic [13:0] rem_c_next;
    logic        leap_next;
    logic [11:0] year_next;

    assign prod_next = in_hours * SPAN_MUL;

    always_comb
    begin
        span_est = prod_a_reg[41:36];
        span_x   = 21'(span_est * SPAN_HOURS);
        rem_raw  = 17'(hours_a_reg - span_x);
        if (rem_raw >= 17'(SPAN_HOURS))
        begin
            span_next  = span_est + 6'd1;
            rem_b_next = 16'(rem_raw - 17'(SPAN_HOURS));
        end
        else
        begin
            span_next  = span_est;
            rem_b_next = 16'(rem_raw);
        end
    end

    // Each span starts two years after a leap year: common, common, leap, common.
    always_comb
    begin
        if (rem_b_reg < 16'(YEAR_HOURS))
        begin
            yoff       = 2'd0;
            rem_c_next = 14'(rem_b_reg);
        end
        else if (rem_b_reg < 16'(2 * YEAR_HOURS))
        begin
            yoff       = 2'd1;
            rem_c_next = 14'(rem_b_reg - 16'(YEAR_HOURS));
        end
        else if (rem_b_reg < 16'(YEAR_HOURS) + 16'(YEAR_HOURS) + 16'(LEAP_YEAR_HOURS))
        begin
            yoff       = 2'd2;
            rem_c_next = 14'(rem_b_reg - 16'(2 * YEAR_HOURS));
        end
        else
        begin
            yoff       = 2'd3;
            rem_c_next = 14'(rem_b_reg - 16'(YEAR_HOURS) - 16'(YEAR_HOURS)
                             - 16'(LEAP_YEAR_HOURS));
        end
        leap_next = (yoff == 2'd2);
        year_next = EPOCH_YEAR + 12'({span_b_reg, 2'b00}) + 12'(yoff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hours_a_reg <= in_hours;
            prod_a_reg  <= prod_next;
            ms_a_reg    <= in_ms;
            span_b_reg  <= span_next;
            rem_b_reg   <= rem_b_next;
            ms_b_reg    <= ms_a_reg;
            year_c_reg  <= year_next;
            leap_c_reg  <= leap_next;
            rem_c_reg   <= rem_c_next;
            ms_c_reg    <= ms_b_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_year  = year_c_reg;
    assign out_leap  = leap_c_reg;
    assign out_rem   = rem_c_reg;
    assign out_ms    = ms_c_reg;

endmodule

### src/ets_date.sv
// ets_date: two stages from hour of year to day of year and hour, then month and day.
// Holds the output register of the block. Uses ets_pkg (month table).
module ets_date (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [11:0]     in_year,
    input  logic            in_leap,
    input  logic [13:0]     in_rem,
    input  ets_pkg::ets_ms_t in_ms,
    output logic            out_valid,
    output logic [11:0]     out_year,
    output logic [3:0]      out_month,
    output logic [4:0]      out_day,
    output logic [4:0]      out_hour,
    output ets_pkg::ets_ms_t out_ms
);
    import ets_pkg::*;

    // stage d: day split
    logic        vd_reg;
    logic [11:0] year_d_reg;
    logic        leap_d_reg;
    logic [8:0]  doy_d_reg;
    logic [4:0]  hour_d_reg;
    ets_ms_t     ms_d_reg;
    // stage e: result
    logic        ve_reg;
    logic [11:0] year_e_reg;
    logic [3:0]  month_e_reg;
    logic [4:0]  day_e_reg;
    logic [4:0]  hour_e_reg;
    ets_ms_t     ms_e_reg;

    logic [25:0] dprod;
    logic [9:0]  doy_est;
    logic [13:0] d_x24;
    logic [5:0]  hr_raw;
    logic [8:0]  doy_next;
    logic [4:0]  hour_next;
    logic [8:0]  dcom;
    logic [3:0]  midx;
    logic [3:0]  month_next;
    logic [4:0]  day_next;

    always_comb
    begin
        dprod   = in_rem * DAY_MUL;
        doy_est = dprod[25:16];
        d_x24   = 14'(doy_est * HOURS_PER_DAY);
        hr_raw  = 6'(in_rem - d_x24);
        if (hr_raw >= 6'(HOURS_PER_DAY))
        begin
            doy_next  = 9'(doy_est + 10'd1);
            hour_next = 5'(hr_raw - 6'(HOURS_PER_DAY));
        end
        else
        begin
            doy_next  = 9'(doy_est);
            hour_next = 5'(hr_raw);
        end
    end

    // Leap day is its own case; later days of a leap year fold onto the common table.
    always_comb
    begin
        dcom = (leap_d_reg && doy_d_reg > LEAP_DAY_DOY) ? doy_d_reg - 9'd1 : doy_d_reg;
        midx = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (dcom >= month_start(4'(k)))
                midx = 4'(k);
        end
        if (leap_d_reg && doy_d_reg == LEAP_DAY_DOY)
        begin
            month_next = 4'd2;
            day_next   = 5'd29;
        end
        else
        begin
            month_next = midx + 4'd1;
            day_next   = 5'(dcom - month_start(midx) + 9'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (adv)
        begin
            vd_reg <= in_valid;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            year_d_reg  <= in_year;
            leap_d_reg  <= in_leap;
            doy_d_reg   <= doy_next;
            hour_d_reg  <= hour_next;
            ms_d_reg    <= in_ms;
            year_e_reg  <= year_d_reg;
            month_e_reg <= month_next;
            day_e_reg   <= day_next;
            hour_e_reg  <= hour_d_reg;
            ms_e_reg    <= ms_d_reg;
        end
    end

    assign out_valid = ve_reg;
    assign out_year  = year_e_reg;
    assign out_month = month_e_reg;
    assign out_day   = day_e_reg;
    assign out_hour  = hour_e_reg;
    assign out_ms    = ms_e_reg;

endmodule

### src/epoch_seconds_to_local_date.sv
// Channel  | Handshake           | Payload                                   | Dir
// ---------+---------------------+-------------------------------------------+----
// input    | in_valid / in_stall | epoch_seconds[31:0]                       | in
// output   | out_valid/out_stall | year, month, day, hour, minute, second    | out
//
// One transaction in, one out. Accepts a timestamp every cycle unless in_stall is high.
// Pipeline: offset add, two 2-stage divide-by-60, 3-stage year split, 2-stage date split.
// The pipeline moves as a whole: a stalled output holds every stage and in_stall follows.
// rst_n clears only the valid bits; data registers are not reset.
//
// epoch_seconds_to_local_date: Unix seconds to calendar date and time in UTC+8.
// Depends on ets_pkg, ets_div60, ets_year, ets_date.
module epoch_seconds_to_local_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);
    import ets_pkg::*;

    // Global advance: everything moves unless a finished result is held.
    logic        adv;

    // Offset stage: local seconds, 33 bits so the add never wraps.
    logic        v0_reg;
    logic [32:0] local_reg;

    logic        v_min;
    logic [26:0] minutes;
    ets_ms_t     ms_min;

    logic        v_hr;
    logic [26:0] hours_wide;
    ets_ms_t     ms_hr;

    logic        v_yr;
    logic [11:0] yr_year;
    logic        yr_leap;
    logic [13:0] yr_rem;
    ets_ms_t     ms_yr;

    ets_ms_t     ms_out;

    assign in_stall = out_valid && out_stall;
    assign adv      = !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            local_reg <= 33'(epoch_seconds) + ZONE_OFFSET_SEC;
    end

    // seconds -> minutes; second lands in the side word
    ets_div60 u_div_sec (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v0_reg),
        .in_value  (local_reg),
        .in_ms     ('0),
        .out_valid (v_min),
        .out_quot  (minutes),
        .out_ms    (ms_min)
    );

    // minutes -> hours; minute shifts in and pushes the second down
    ets_div60 u_div_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_min),
        .in_value  (33'(minutes)),
        .in_ms     (ms_min),
        .out_valid (v_hr),
        .out_quot  (hours_wide),
        .out_ms    (ms_hr)
    );

    // hours since epoch fit in 21 bits for any 32-bit input
    ets_year u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_hr),
        .in_hours  (hours_wide[20:0]),
        .in_ms     (ms_hr),
        .out_valid (v_yr),
        .out_year  (yr_year),
        .out_leap  (yr_leap),
        .out_rem   (yr_rem),
        .out_ms    (ms_yr)
    );

    ets_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_yr),
        .in_year   (yr_year),
        .in_leap   (yr_leap),
        .in_rem    (yr_rem),
        .in_ms     (ms_yr),
        .out_valid (out_valid),
        .out_year  (year),
        .out_month (month),
        .out_day   (day),
        .out_hour  (hour),
        .out_ms    (ms_out)
    );

    assign minute = ms_out.minute;
    assign second = ms_out.second;

endmodule

### src/ets_checker.sv
// ets_checker: port-level assertions for epoch_seconds_to_local_date, plus its bind.
// No package dependency.
module ets_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] epoch_seconds,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    // A stalled input transaction stays presented and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(epoch_seconds))
        else $error("input transaction changed while stalled");

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(year) && $stable(month)
            && $stable(day) && $stable(hour) && $stable(minute) && $stable(second))
        else $error("output transaction changed while stalled");

    // Input backpressure comes only from a held result.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the output hold");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
            && (month != 4'd2 || day <= 5'd29))
        else $error("month/day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
            && year >= 12'd1970)
        else $error("time of day or year out of range");

endmodule

bind epoch_seconds_to_local_date ets_checker u_ets_checker (.*);
